// ===== rtl/mpt_pkg.sv =====
package mpt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int RESULT_LIMIT  = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(RESULT_LIMIT + 1);

  localparam int MAC_W  = 48;
  localparam int RSSI_W = 8;
  localparam int MS_W   = 32;

  localparam int S_DATA_W = MAC_W + RSSI_W + MS_W;
  localparam int M_DATA_W = MAC_W + RSSI_W;

  localparam logic [MS_W-1:0] TIMEOUT_RESET = 32'd60000;

  typedef enum logic [0:0] {
    OP_PROBE = 1'b0,
    OP_SWEEP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_IN   = 2'd0,
    EV_OUT  = 2'd1,
    EV_FULL = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic [MAC_W-1:0]         mac;
    logic signed [RSSI_W-1:0] rssi;
    logic [MS_W-1:0]          seen;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             set_valid;
    logic             clr_valid;
    logic [IDX_W-1:0] clr_addr;
  } tbl_req_t;

  // lowest free entry; zero when none is free
  function automatic logic [IDX_W-1:0] first_free(input logic [TABLE_ENTRIES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== rtl/mpt_store.sv =====
module mpt_store (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mpt_pkg::tbl_req_t                      req,
  output mpt_pkg::entry_t                        rdata,
  output logic [mpt_pkg::TABLE_ENTRIES-1:0]      valid
);
  import mpt_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rdata <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (req.set_valid) valid[req.wr_addr] <= 1'b1;
      if (req.clr_valid) valid[req.clr_addr] <= 1'b0;
    end
  end

endmodule

// ===== rtl/mac_presence_table_aging.sv =====
// Presence table with aging: 16 device entries (MAC, best RSSI, last-seen time).
// Input stream (s_*): one word per probe or sweep, kind in s_tuser.
// Output stream (m_*): device in / device out / table full events; m_tlast
// marks the final event caused by one input word.
// Configuration (cfg_*): timeout in ms, always ready. The timeout must be
// written between items; the block itself does not enforce this.
// Each entry is visited in ST_READ (memory read), then in ST_CHECK (compare
// and write back). A probe walks from entry 0 and stops at a hit; a miss or
// a sweep walks all 16 entries, and each event handed to the output register
// takes a ST_PUSH step. The table walk sets how long one item takes.
// s_tready is high only between items; one item is worked on at a time.
// A sweep event is held back one step so the final one can be marked.
// When the receiver stalls, the result waits in the output register and the
// walk holds until it is taken.
// Reset clears all entry valid bits at once, empties the output register and
// loads the timeout with 60000 ms; the block is ready in the next cycle.
module mac_presence_table_aging (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // mac [47:0], rssi [55:48], now_ms [87:56]
  input  logic [mpt_pkg::S_DATA_W-1:0]   s_tdata,
  // operation [0]
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // dev_mac [47:0], dev_rssi [55:48]
  output logic [mpt_pkg::M_DATA_W-1:0]   m_tdata,
  // event_res [1:0]
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [31:0]                    cfg_data
);
  import mpt_pkg::*;

  state_t state, state_next;

  logic [MS_W-1:0]          timeout;
  op_t                      op;
  logic [MAC_W-1:0]         p_mac;
  logic signed [RSSI_W-1:0] p_rssi;
  logic [MS_W-1:0]          p_now;
  logic [IDX_W-1:0]         idx;
  logic [CNT_W-1:0]         cnt;
  logic                     have_pend;
  logic                     final_push;
  event_t                   pend_ev;
  logic [MAC_W-1:0]         pend_mac;
  logic signed [RSSI_W-1:0] pend_rssi;

  tbl_req_t                 req;
  entry_t                   ent;
  logic [TABLE_ENTRIES-1:0] valid;

  logic             in_fire;
  logic             out_free;
  logic             at_end;
  logic             ent_v;
  logic             match;
  logic             expired;
  logic             any_free;
  logic [IDX_W-1:0] free_idx;
  logic [MS_W-1:0]  age;

  mpt_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (ent),
    .valid (valid)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign at_end   = (idx == IDX_W'(TABLE_ENTRIES - 1));
  assign ent_v    = valid[idx];
  assign match    = ent_v && (ent.mac == p_mac);
  assign age      = p_now - ent.seen;
  assign expired  = ent_v && (age > timeout) && (cnt < CNT_W'(RESULT_LIMIT));
  assign any_free = !(&valid);
  assign free_idx = first_free(valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (op == OP_PROBE) begin
          if (match)       state_next = ST_IDLE;
          else if (at_end) state_next = ST_PUSH;
          else             state_next = ST_READ;
        end else begin
          if (expired && have_pend)        state_next = ST_PUSH;
          else if (!at_end)                state_next = ST_READ;
          else if (expired || have_pend)   state_next = ST_PUSH;
          else                             state_next = ST_IDLE;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          if (final_push)  state_next = ST_IDLE;
          else if (at_end) state_next = ST_PUSH;
          else             state_next = ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // table accesses
  always_comb begin
    req = '0;
    req.rd_addr  = idx;
    req.clr_addr = idx;
    req.wr_addr  = idx;
    req.wr_data  = '{mac: p_mac, rssi: p_rssi, seen: p_now};
    unique case (state)
      ST_READ: begin
        req.rd_en = 1'b1;
      end
      ST_CHECK: begin
        if (op == OP_PROBE) begin
          if (match) begin
            // refresh time, keep the stronger RSSI
            req.wr_en = 1'b1;
            if (!($signed(p_rssi) > $signed(ent.rssi))) req.wr_data.rssi = ent.rssi;
          end else if (at_end && any_free) begin
            req.wr_en     = 1'b1;
            req.wr_addr   = free_idx;
            req.set_valid = 1'b1;
          end
        end else begin
          req.clr_valid = expired;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

  // walk control and the held-back event
  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend  <= 1'b0;
      final_push <= 1'b0;
      idx        <= '0;
      cnt        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            op         <= op_t'(s_tuser[0]);
            p_mac      <= s_tdata[MAC_W-1:0];
            p_rssi     <= s_tdata[MAC_W+RSSI_W-1:MAC_W];
            p_now      <= s_tdata[S_DATA_W-1:MAC_W+RSSI_W];
            idx        <= '0;
            cnt        <= '0;
            have_pend  <= 1'b0;
            final_push <= 1'b0;
          end
        end
        ST_CHECK: begin
          if (op == OP_PROBE) begin
            if (!match) begin
              if (at_end) begin
                pend_ev    <= any_free ? EV_IN : EV_FULL;
                pend_mac   <= p_mac;
                pend_rssi  <= p_rssi;
                have_pend  <= 1'b1;
                final_push <= 1'b1;
              end else begin
                idx <= idx + 1'b1;
              end
            end
          end else begin
            if (expired) cnt <= cnt + 1'b1;
            if (expired && have_pend) begin
              // hand over the older event first; rdata holds this entry
              final_push <= 1'b0;
            end else begin
              final_push <= 1'b1;
              if (!at_end) idx <= idx + 1'b1;
              if (expired) begin
                pend_ev   <= EV_OUT;
                pend_mac  <= ent.mac;
                pend_rssi <= ent.rssi;
                have_pend <= 1'b1;
              end
            end
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            if (final_push) begin
              have_pend <= 1'b0;
            end else begin
              pend_ev   <= EV_OUT;
              pend_mac  <= ent.mac;
              pend_rssi <= ent.rssi;
              if (at_end) final_push <= 1'b1;
              else        idx <= idx + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_PUSH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && out_free) begin
      m_tdata <= {pend_rssi, pend_mac};
      m_tuser <= pend_ev;
      m_tlast <= final_push;
    end
  end

endmodule

// ===== rtl/mpt_checker.sv =====
module mpt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mpt_pkg::M_DATA_W-1:0]   m_tdata,
  input logic [1:0]                     m_tuser,
  input logic                           m_tlast
);
  import mpt_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output not empty or input not ready after reset");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= 2'(EV_FULL))
    else $error("undefined event code");

  // in and full events are the only result of a probe
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == 2'(EV_IN) || m_tuser == 2'(EV_FULL)) |-> m_tlast)
    else $error("probe event not marked last");

endmodule

bind mac_presence_table_aging mpt_checker u_mpt_checker (.*);

// ===== dv/tb_mac_presence_table_aging.sv =====
`timescale 1ns / 100ps

module tb_mac_presence_table_aging;
  import mpt_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 19;
  localparam int MAC_POOL       = 24;
  localparam int MAX_GAP        = 20;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_IN,
    ROW_FULL
  } row_kind_t;

  typedef struct {
    op_t                      op;
    logic [MAC_W-1:0]         mac;
    logic signed [RSSI_W-1:0] rssi;
    logic [MS_W-1:0]          now;
    row_kind_t                kind;
  } stim_row_t;

  typedef struct {
    event_t                   ev;
    logic [MAC_W-1:0]         mac;
    logic signed [RSSI_W-1:0] rssi;
    logic                     last;
  } dev_event_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic [0:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [31:0]           cfg_data;

  // shadow of the device table
  logic                     tbl_valid [TABLE_ENTRIES];
  logic [MAC_W-1:0]         tbl_mac   [TABLE_ENTRIES];
  logic signed [RSSI_W-1:0] tbl_rssi  [TABLE_ENTRIES];
  logic [MS_W-1:0]          tbl_seen  [TABLE_ENTRIES];
  logic [MS_W-1:0]          timeout_ms_q;

  dev_event_t step_events[$];
  dev_event_t pending_events[$];

  int errors       = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  mac_presence_table_aging dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // work out the events caused by one word and update the shadow table
  function automatic void predict_presence(input op_t op, input logic [MAC_W-1:0] mac,
                                           input logic signed [RSSI_W-1:0] rssi,
                                           input logic [MS_W-1:0] now);
    int free_idx;
    logic [MS_W-1:0] age;
    free_idx = -1;
    if (op == OP_PROBE) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_mac[i] == mac) begin
          if (rssi > tbl_rssi[i]) tbl_rssi[i] = rssi;
          tbl_seen[i] = now;
          return;
        end
      end
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
        if (!tbl_valid[i]) free_idx = i;
      end
      if (free_idx < 0) begin
        step_events.push_back('{EV_FULL, mac, rssi, 1'b1});
      end else begin
        tbl_valid[free_idx] = 1'b1;
        tbl_mac[free_idx]   = mac;
        tbl_rssi[free_idx]  = rssi;
        tbl_seen[free_idx]  = now;
        step_events.push_back('{EV_IN, mac, rssi, 1'b1});
      end
    end else begin
      for (int i = 0; i < TABLE_ENTRIES && step_events.size() < RESULT_LIMIT; i++) begin
        age = now - tbl_seen[i];
        if (tbl_valid[i] && age > timeout_ms_q) begin
          step_events.push_back('{EV_OUT, tbl_mac[i], tbl_rssi[i], 1'b0});
          tbl_valid[i] = 1'b0;
        end
      end
      if (step_events.size() > 0) step_events[$].last = 1'b1;
    end
  endfunction

  task automatic send_item(input op_t op, input logic [MAC_W-1:0] mac,
                           input logic signed [RSSI_W-1:0] rssi,
                           input logic [MS_W-1:0] now, input row_kind_t kind);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {now, rssi, mac};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    step_events.delete();
    predict_presence(op, mac, rssi, now);
    case (kind)
      ROW_PREDICT: begin
        foreach (step_events[k]) pending_events.push_back(step_events[k]);
      end
      ROW_IN:   pending_events.push_back('{EV_IN, mac, rssi, 1'b1});
      ROW_FULL: pending_events.push_back('{EV_FULL, mac, rssi, 1'b1});
      default: ;
    endcase
  endtask

  task automatic write_timeout(input logic [MS_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    timeout_ms_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // let every expected event arrive, then give a hit probe time to finish its walk
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    dev_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch("word with nothing expected", m_tdata, '0);
      end else begin
        want = pending_events.pop_front();
        if (m_tuser !== want.ev) flag_mismatch("event", m_tuser, want.ev);
        if (m_tdata[MAC_W-1:0] !== want.mac) flag_mismatch("mac", m_tdata[MAC_W-1:0], want.mac);
        if (m_tdata[MAC_W +: RSSI_W] !== want.rssi)
          flag_mismatch("rssi", m_tdata[MAC_W +: RSSI_W], want.rssi);
        if (m_tlast !== want.last) flag_mismatch("last", m_tlast, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t                rows[$];
    logic [MAC_W-1:0]         mac_pool[MAC_POOL];
    logic [MS_W-1:0]          phase_timeout[4];
    int                       phase_idle[4];
    int                       phase_stall[4];
    logic [MS_W-1:0]          clock_ms;
    logic [MAC_W-1:0]         mac;
    logic signed [RSSI_W-1:0] rssi;
    op_t                      op;
    int                       pick;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    timeout_ms_q = TIMEOUT_RESET;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i]   = '0;
      tbl_rssi[i]  = '0;
      tbl_seen[i]  = '0;
    end

    // directed rows, run with the reset timeout of 60000 ms
    rows.push_back('{OP_SWEEP, 48'h0,            8'h00, 32'd0,         ROW_NONE});
    rows.push_back('{OP_PROBE, 48'h0,            8'h80, 32'd0,         ROW_IN});
    rows.push_back('{OP_PROBE, 48'hFFFF_FFFF_FFFF, 8'h7F, 32'hFFFF_FFFF, ROW_IN});
    rows.push_back('{OP_PROBE, 48'h0,            8'h7F, 32'd10,        ROW_NONE});
    rows.push_back('{OP_PROBE, 48'h0,            8'hFF, 32'd20,        ROW_NONE});
    for (int i = 0; i < TABLE_ENTRIES - 2; i++)
      rows.push_back('{OP_PROBE, 48'h0200_0000_0000 + 48'(i), 8'(i * 9 - 60),
                       32'(100 * (i + 1)), ROW_IN});
    rows.push_back('{OP_PROBE, 48'h5555_AAAA_5555, 8'h00, 32'd2000, ROW_FULL});
    rows.push_back('{OP_PROBE, 48'hFFFF_FFFF_FFFF, 8'hFB, 32'd3000, ROW_NONE});
    // just short of the timeout, then just past it for all but one entry
    rows.push_back('{OP_SWEEP, 48'hA5A5_A5A5_A5A5, 8'h5A, 32'd60020, ROW_PREDICT});
    rows.push_back('{OP_SWEEP, 48'h0,            8'h00, 32'd61401,     ROW_PREDICT});
    rows.push_back('{OP_SWEEP, 48'h0,            8'h00, 32'hFFFF_FFFF, ROW_PREDICT});
    rows.push_back('{OP_PROBE, 48'hFFFF_FFFF_FFFF, 8'h01, 32'd0,       ROW_IN});

    for (int k = 0; k < MAC_POOL; k++) mac_pool[k] = {16'($urandom), 32'($urandom)};
    phase_timeout = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'($urandom_range(500, 5000))};
    phase_idle    = '{0, 54, 0, 21};
    phase_stall   = '{0, 0, 54, 21};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r])
      send_item(rows[r].op, rows[r].mac, rows[r].rssi, rows[r].now, rows[r].kind);

    clock_ms = $urandom;
    for (int p = 0; p < 4; p++) begin
      drain_results();
      write_timeout(phase_timeout[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(1500);
        op   = (pick < 20) ? OP_SWEEP : OP_PROBE;
        mac  = (pick >= 90) ? {16'($urandom), 32'($urandom)}
                            : mac_pool[$urandom_range(MAC_POOL - 1)];
        rssi = 8'($urandom);
        send_item(op, mac, rssi, clock_ms, ROW_PREDICT);
      end
    end
    drain_results();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mpt_pkg.sv
rtl/mpt_store.sv
rtl/mac_presence_table_aging.sv
rtl/mpt_checker.sv
dv/tb_mac_presence_table_aging.sv
